// ----- hw/rtl/b2da_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// shared types and constants of the binary to decimal ascii converter
// ----------------------------------------------------------------------------
package b2da_pkg;

	localparam int VALUE_W            = 64;
	localparam int STEP_W             = $clog2(VALUE_W);
	localparam int DIGIT_W            = 4;
	localparam int CHAR_W             = 6;
	localparam int DEFAULT_MAX_DIGITS = 20;

	localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'h30;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EMIT
	} state_t;

	// control word broadcast to every digit cell
	typedef struct packed {
		logic load;   // clear digit, new transaction
		logic dabble; // add-3 correction and shift one bit up
		logic move;   // shift whole digits one cell up
	} cell_ctl_t;

endpackage

// ----- hw/rtl/b2da_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_cell
// one bcd digit of the conversion chain
// ----------------------------------------------------------------------------
module b2da_cell
	import b2da_pkg::*;
(
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic               bit_in,
	input  logic [DIGIT_W-1:0] digit_in,
	output logic [DIGIT_W-1:0] digit,
	output logic               carry
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] corr;

	always_comb begin
		corr = (digit_q >= DABBLE_LIMIT) ? digit_q + DABBLE_ADJ : digit_q;
	end

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {corr[DIGIT_W-2:0], bit_in};
		end else if (ctl.move) begin
			digit_q <= digit_in;
		end
	end

	assign digit = digit_q;
	assign carry = corr[DIGIT_W-1];

endmodule

// ----- hw/rtl/b2da_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_ctrl
// sequencer, leading zero skip and output register
// ----------------------------------------------------------------------------
module b2da_ctrl
	import b2da_pkg::*;
#(
	parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic [DIGIT_W-1:0] top_digit,
	output cell_ctl_t          ctl,
	output logic [CHAR_W-1:0]  ascii_char,
	output logic               last
);

	localparam int REM_W = $clog2(MAX_DIGITS + 1);

	state_t             state_q, state_d;
	logic [STEP_W-1:0]  step_q;
	logic [REM_W-1:0]   remain_q;
	logic               lead_q;
	logic               out_valid_q;
	logic [DIGIT_W-1:0] char_q;
	logic               last_q;

	logic slot_free;
	logic skip;
	logic emit;
	logic final_digit;
	logic step_done;

	assign slot_free   = !out_valid_q || out_ready;
	assign final_digit = (remain_q == REM_W'(1));
	assign step_done   = (step_q == STEP_W'(VALUE_W - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CONVERT;
			end
			ST_CONVERT: begin
				if (step_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit && final_digit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		skip       = 1'b0;
		emit       = 1'b0;
		ctl        = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			ST_CONVERT: begin
				ctl.dabble = 1'b1;
			end
			ST_EMIT: begin
				// leading zeros leave the chain without a transaction
				skip     = !lead_q && (top_digit == '0) && !final_digit;
				emit     = !skip && slot_free;
				ctl.move = skip || emit;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			remain_q    <= '0;
			lead_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				step_q <= '0;
			end else if (ctl.dabble) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (ctl.dabble && step_done) begin
				remain_q <= REM_W'(MAX_DIGITS);
				lead_q   <= 1'b0;
			end else if (ctl.move) begin
				remain_q <= remain_q - REM_W'(1);
				if (emit) lead_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= top_digit;
			last_q <= final_digit;
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = ASCII_ZERO + CHAR_W'(char_q);
	assign last       = last_q;

`ifndef ASSERT_OFF
	a_emit_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (remain_q != '0))
		else $error("emit phase with no digits left");

	a_ctl_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.dabble, ctl.move}))
		else $error("conflicting cell controls");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> (state_q == ST_CONVERT) && (step_q == '0))
		else $error("conversion did not start at step zero");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && final_digit) |=> (state_q == ST_IDLE) && out_valid_q && last_q)
		else $error("final digit did not end the transaction");
`endif

endmodule

// ----- hw/rtl/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// 64-bit unsigned binary to decimal ascii digits, most significant first
// ----------------------------------------------------------------------------
// sequence: the accepting cycle loads the value, then the 64 double dabble
//   steps run, leading zeros are skipped and one digit per cycle follows
//   while out_ready stays high; a new number is accepted only once the
//   last digit of the previous one has been emitted
// reset: arst_n clears the sequencer and the output valid flag; digit cells
//   and the value shift register are cleared or loaded on each new number
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
	import b2da_pkg::*;
#(
	parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  ascii_char,
	output logic               last
);

	cell_ctl_t          ctl;
	logic [VALUE_W-1:0] value_q;

	// link i feeds cell i; link MAX_DIGITS is the top of the chain
	logic               chain_bit   [MAX_DIGITS+1];
	logic [DIGIT_W-1:0] chain_digit [MAX_DIGITS+1];

	// binary operand shifts out msb first into the lowest digit cell
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= value;
		end else if (ctl.dabble) begin
			value_q <= {value_q[VALUE_W-2:0], 1'b0};
		end
	end

	assign chain_bit[0]   = value_q[VALUE_W-1];
	assign chain_digit[0] = '0;

	// row of bcd cells, least significant digit at index zero; the carry out
	// of the top cell drops digits above the cap
	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		b2da_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.bit_in   (chain_bit[i]),
			.digit_in (chain_digit[i]),
			.digit    (chain_digit[i+1]),
			.carry    (chain_bit[i+1])
		);
	end

	// sequencer skips leading zeros at the chain top and emits the rest
	b2da_ctrl #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.top_digit  (chain_digit[MAX_DIGITS]),
		.ctl        (ctl),
		.ascii_char (ascii_char),
		.last       (last)
	);

endmodule
